/* rtl/core/pqe_pkg.sv */
package pqe_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_QUEUES  = 3;

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W    = $clog2(NUM_QUEUES * QUEUE_DEPTH);
    localparam int QIDX_W    = 2;
    localparam int ID_W      = 16;
    localparam int PRIO_W    = 3;
    localparam int OPRIO_W   = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int BUD_W     = CFG_W + 2;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic PH_GREEN = 1'b0;
    localparam logic PH_BASE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COST  = 2'd2;

    localparam logic [CFG_W-1:0] GREEN_RST = 16'd10;
    localparam logic [CFG_W-1:0] BASE_RST  = 16'd80;
    localparam logic [CFG_W-1:0] COST_RST  = 16'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SWITCH,
        ST_READ
    } t_state;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [QIDX_W-1:0] q;
    } t_qreq;

    typedef struct packed {
        logic [NUM_QUEUES-1:0] ne;
        logic                  full;
        logic [ADDR_W-1:0]     addr;
    } t_qstat;

    typedef struct packed {
        logic [BUD_W-1:0] a;
        logic [BUD_W-1:0] b;
    } t_alu_req;

endpackage

/* rtl/core/pqe_if.sv */
interface pqe_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [pqe_pkg::PRIO_W-1:0]  priority_req;
    logic [pqe_pkg::ID_W-1:0]    packet_id;

    modport source(output valid, command, priority_req, packet_id, input ready);
    modport sink(input valid, command, priority_req, packet_id, output ready);
endinterface

interface pqe_out_if;
    logic                        valid;
    logic                        ready;
    logic [pqe_pkg::OPRIO_W-1:0] out_priority;
    logic [pqe_pkg::ID_W-1:0]    out_packet_id;
    logic                        budget_phase;
    logic                        last;

    modport source(output valid, out_priority, out_packet_id, budget_phase, last,
                   input ready);
    modport sink(input valid, out_priority, out_packet_id, budget_phase, last,
                 output ready);
endinterface

/* rtl/core/pqe_alu.sv */
module pqe_alu (
    input  pqe_pkg::t_alu_req            i_req,
    output logic signed [pqe_pkg::BUD_W-1:0] o_diff
);

    // shared signed subtractor for budget charge and base budget setup
    assign o_diff = $signed(i_req.a) - $signed(i_req.b);

endmodule

/* rtl/core/pqe_store.sv */
module pqe_store (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic                        i_re,
    input  logic [pqe_pkg::ADDR_W-1:0]  i_addr,
    input  logic [pqe_pkg::ID_W-1:0]    i_wdata,
    output logic [pqe_pkg::ID_W-1:0]    o_rdata
);

    logic [pqe_pkg::ID_W-1:0] r_mem [pqe_pkg::NUM_QUEUES * pqe_pkg::QUEUE_DEPTH];
    logic [pqe_pkg::ID_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/pqe_qctl.sv */
module pqe_qctl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pqe_pkg::t_qreq  i_req,
    output pqe_pkg::t_qstat o_stat
);

    logic [pqe_pkg::PTR_W-1:0] r_head  [pqe_pkg::NUM_QUEUES];
    logic [pqe_pkg::CNT_W-1:0] r_count [pqe_pkg::NUM_QUEUES];

    logic [pqe_pkg::PTR_W-1:0] w_head;
    logic [pqe_pkg::CNT_W-1:0] w_count;
    logic [pqe_pkg::CNT_W:0]   w_sum;
    logic [pqe_pkg::PTR_W-1:0] w_tail;
    logic [pqe_pkg::PTR_W-1:0] w_head_inc;
    logic [pqe_pkg::PTR_W-1:0] w_slot;
    logic                      w_full;

    assign w_head  = r_head[i_req.q];
    assign w_count = r_count[i_req.q];
    assign w_full  = (w_count == pqe_pkg::CNT_W'(pqe_pkg::QUEUE_DEPTH));

    // tail slot: head plus count, wrapped once
    always_comb begin
        w_sum = (pqe_pkg::CNT_W + 1)'(w_head) + (pqe_pkg::CNT_W + 1)'(w_count);
        if (w_sum >= (pqe_pkg::CNT_W + 1)'(pqe_pkg::QUEUE_DEPTH)) begin
            w_sum = w_sum - (pqe_pkg::CNT_W + 1)'(pqe_pkg::QUEUE_DEPTH);
        end
        w_tail = w_sum[pqe_pkg::PTR_W-1:0];
    end

    assign w_head_inc = (w_head == pqe_pkg::PTR_W'(pqe_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : w_head + 1'b1;
    assign w_slot     = i_req.push ? w_tail : w_head;

    always_comb begin
        for (int i = 0; i < pqe_pkg::NUM_QUEUES; i++) begin
            o_stat.ne[i] = (r_count[i] != '0);
        end
        o_stat.full = w_full;
        o_stat.addr = pqe_pkg::ADDR_W'(i_req.q) * pqe_pkg::ADDR_W'(pqe_pkg::QUEUE_DEPTH)
                    + pqe_pkg::ADDR_W'(w_slot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pqe_pkg::NUM_QUEUES; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
        end else if (i_req.push && !w_full) begin
            r_count[i_req.q] <= w_count + 1'b1;
        end else if (i_req.pop) begin
            r_head[i_req.q]  <= w_head_inc;
            r_count[i_req.q] <= w_count - 1'b1;
        end
    end

endmodule

/* rtl/core/priority_queue_energy_budget_drain_core.sv */
// An arrival is taken while idle and the block stays ready for the next item.
// A tick loads the budget, forwards each packet by a decide/pop step and a store
// read, ends the green phase, sets up the base budget, forwards base packets the
// same way and closes the tick; output stalls can hold the read and the close.
// Throughput is set by the single shared subtractor and the one-port queue store.
// Reset (synchronous, active low) empties all queues and loads the default budgets.
module priority_queue_energy_budget_drain_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pqe_in_if.sink                           i_in,
    pqe_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [pqe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pqe_pkg::CFG_W-1:0]        i_cfg_data
);

    pqe_pkg::t_state r_state, n_state;

    // configuration
    logic [pqe_pkg::CFG_W-1:0] r_green, r_base, r_cost;

    // tick working state
    logic signed [pqe_pkg::BUD_W-1:0] r_budget, n_budget;
    logic                             r_phase, n_phase;
    logic [pqe_pkg::QIDX_W-1:0]       r_cur_q, n_cur_q;

    // one result held back until we know whether it closes the tick
    logic                             r_pend_valid, n_pend_valid;
    logic [pqe_pkg::QIDX_W-1:0]       r_pend_q, n_pend_q;
    logic                             r_pend_phase, n_pend_phase;
    logic [pqe_pkg::ID_W-1:0]         r_pend_id, n_pend_id;

    // output register
    logic                             r_out_valid, n_out_valid;
    logic [pqe_pkg::QIDX_W-1:0]       r_out_q, n_out_q;
    logic [pqe_pkg::ID_W-1:0]         r_out_id, n_out_id;
    logic                             r_out_phase, n_out_phase;
    logic                             r_out_last, n_out_last;

    pqe_pkg::t_qreq    w_qreq;
    pqe_pkg::t_qstat   w_qstat;
    pqe_pkg::t_alu_req w_alu_req;
    logic signed [pqe_pkg::BUD_W-1:0] w_diff;
    logic [pqe_pkg::ID_W-1:0]         w_rdata;

    logic                       w_in_acc;
    logic                       w_out_free;
    logic                       w_prio_ok;
    logic [pqe_pkg::QIDX_W-1:0] w_arr_q;
    logic [pqe_pkg::QIDX_W-1:0] w_green_q;
    logic [pqe_pkg::QIDX_W-1:0] w_serve_q;
    logic                       w_serve;
    logic                       w_we, w_re;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_prio_ok  = !i_in.priority_req[2] && (i_in.priority_req[1:0] != 2'd0);
    assign w_arr_q    = i_in.priority_req[1:0] - 2'd1;

    // strict priority: lowest nonempty queue index wins
    always_comb begin
        w_green_q = pqe_pkg::QIDX_W'(pqe_pkg::NUM_QUEUES - 1);
        for (int i = pqe_pkg::NUM_QUEUES - 1; i >= 0; i--) begin
            if (w_qstat.ne[i]) begin
                w_green_q = pqe_pkg::QIDX_W'(i);
            end
        end
    end

    assign w_serve_q = (r_phase == pqe_pkg::PH_GREEN) ? w_green_q : '0;

    // the shared subtractor: base minus green when switching phase,
    // otherwise budget minus cost
    always_comb begin
        if (r_state == pqe_pkg::ST_SWITCH) begin
            w_alu_req.a = pqe_pkg::BUD_W'(r_base);
            w_alu_req.b = pqe_pkg::BUD_W'(r_green);
        end else begin
            w_alu_req.a = r_budget;
            w_alu_req.b = pqe_pkg::BUD_W'(r_cost);
        end
    end

    // green: any queue waiting and budget stays >= 0 after the charge
    // base: queue 0 (priority 1) waiting, budget > 0 and strictly > 0 after the charge
    always_comb begin
        if (r_phase == pqe_pkg::PH_GREEN) begin
            w_serve = (|w_qstat.ne) && !w_diff[pqe_pkg::BUD_W-1];
        end else begin
            w_serve = w_qstat.ne[0]
                   && !r_budget[pqe_pkg::BUD_W-1] && (r_budget != '0)
                   && !w_diff[pqe_pkg::BUD_W-1] && (w_diff != '0);
        end
    end

    assign w_qreq.q    = (r_state == pqe_pkg::ST_IDLE) ? w_arr_q : w_serve_q;
    assign w_qreq.push = (r_state == pqe_pkg::ST_IDLE) && w_in_acc
                      && (i_in.command == pqe_pkg::CMD_ARRIVE) && w_prio_ok;
    assign w_qreq.pop  = (r_state == pqe_pkg::ST_DECIDE) && w_serve;
    assign w_we        = w_qreq.push && !w_qstat.full;
    assign w_re        = w_qreq.pop;

    pqe_qctl u_qctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_qreq),
        .o_stat  (w_qstat)
    );

    pqe_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (w_qstat.addr),
        .i_wdata (i_in.packet_id),
        .o_rdata (w_rdata)
    );

    pqe_alu u_alu (
        .i_req  (w_alu_req),
        .o_diff (w_diff)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_budget     = r_budget;
        n_phase      = r_phase;
        n_cur_q      = r_cur_q;
        n_pend_valid = r_pend_valid;
        n_pend_q     = r_pend_q;
        n_pend_phase = r_pend_phase;
        n_pend_id    = r_pend_id;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_q      = r_out_q;
        n_out_id     = r_out_id;
        n_out_phase  = r_out_phase;
        n_out_last   = r_out_last;

        case (r_state)
            pqe_pkg::ST_IDLE: begin
                // valid arrivals are written straight into the store on transfer unless the queue is full
                if (w_in_acc && (i_in.command == pqe_pkg::CMD_TICK)) begin
                    n_budget = pqe_pkg::BUD_W'(r_green);
                    n_phase  = pqe_pkg::PH_GREEN;
                    n_state  = pqe_pkg::ST_DECIDE;
                end
            end
            pqe_pkg::ST_DECIDE: begin
                if (w_serve) begin
                    // pop the head, charge the budget, read lands next cycle
                    n_budget = w_diff;
                    n_cur_q  = w_serve_q;
                    n_state  = pqe_pkg::ST_READ;
                end else if (r_phase == pqe_pkg::PH_GREEN) begin
                    n_state = pqe_pkg::ST_SWITCH;
                end else if (!r_pend_valid) begin
                    n_state = pqe_pkg::ST_IDLE;
                end else if (w_out_free) begin
                    // close the tick: held result is the last one
                    n_out_valid  = 1'b1;
                    n_out_q      = r_pend_q;
                    n_out_id     = r_pend_id;
                    n_out_phase  = r_pend_phase;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = pqe_pkg::ST_IDLE;
                end
            end
            pqe_pkg::ST_SWITCH: begin
                n_budget = w_diff;
                n_phase  = pqe_pkg::PH_BASE;
                n_state  = pqe_pkg::ST_DECIDE;
            end
            pqe_pkg::ST_READ: begin
                // hold until the previous result can move to the output
                if (!r_pend_valid || w_out_free) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out_q     = r_pend_q;
                        n_out_id    = r_pend_id;
                        n_out_phase = r_pend_phase;
                        n_out_last  = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_q     = r_cur_q;
                    n_pend_phase = r_phase;
                    n_pend_id    = w_rdata;
                    n_state      = pqe_pkg::ST_DECIDE;
                end
            end
            default: begin
                n_state = pqe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pqe_pkg::ST_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= pqe_pkg::PH_GREEN;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_phase      <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_budget     <= n_budget;
        r_cur_q      <= n_cur_q;
        r_pend_q     <= n_pend_q;
        r_pend_phase <= n_pend_phase;
        r_pend_id    <= n_pend_id;
        r_out_q      <= n_out_q;
        r_out_id     <= n_out_id;
        r_out_phase  <= n_out_phase;
        r_out_last   <= n_out_last;
    end

    // configuration registers; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_green <= pqe_pkg::GREEN_RST;
            r_base  <= pqe_pkg::BASE_RST;
            r_cost  <= pqe_pkg::COST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pqe_pkg::CFG_GREEN: r_green <= i_cfg_data;
                pqe_pkg::CFG_BASE:  r_base  <= i_cfg_data;
                pqe_pkg::CFG_COST:  r_cost  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready          = (r_state == pqe_pkg::ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.out_priority  = r_out_q + 2'd1;
    assign o_out.out_packet_id = r_out_id;
    assign o_out.budget_phase  = r_out_phase;
    assign o_out.last          = r_out_last;

endmodule

/* rtl/core/pqe_checker.sv */
module pqe_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_in_command,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [pqe_pkg::OPRIO_W-1:0]  i_out_priority,
    input logic [pqe_pkg::ID_W-1:0]     i_out_packet_id,
    input logic                         i_out_phase,
    input logic                         i_out_last
);

    logic w_arrive;

    assign w_arrive = i_in_valid && i_in_ready && (i_in_command == pqe_pkg::CMD_ARRIVE);

    // reset drops any result in flight
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // the block is ready again in the cycle after an arrival
    a_arrive_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_arrive |=> i_in_ready)
        else $error("not ready after arrival");

    // an arrival never produces a result
    a_arrive_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_arrive && !i_out_valid |=> !i_out_valid)
        else $error("result after arrival");

    // only the closing result of a tick can be waiting while idle
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready && i_out_valid |-> i_out_last)
        else $error("non-last result pending while idle");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_priority)
            && $stable(i_out_packet_id) && $stable(i_out_phase) && $stable(i_out_last))
        else $error("stalled result changed");

endmodule

bind priority_queue_energy_budget_drain_core pqe_checker u_pqe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_command    (i_in.command),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_priority  (o_out.out_priority),
    .i_out_packet_id (o_out.out_packet_id),
    .i_out_phase     (o_out.budget_phase),
    .i_out_last      (o_out.last)
);

/* test/tb_priority_queue_energy_budget_drain_core.sv */
module tb_priority_queue_energy_budget_drain_core;

    import pqe_pkg::*;

    // Register index that maps to no register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 8;      // lets a tick close after its last transfer
    localparam int HOLD_CYCLES     = 400;    // long receiver hold-off, fills the block up
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int PRESSURE_PHASE  = 5;
    localparam int LIMIT_CYCLES    = 1_000_000;

    // One forwarded packet as the output channel carries it.
    typedef struct packed {
        logic [OPRIO_W-1:0] prio;
        logic [ID_W-1:0]    id;
        logic               phase;
        logic               last;
    } t_fwd;

    // How a row of the directed table is checked, or that it is a register write.
    typedef enum logic [1:0] {
        RK_ITEM,    // expected transfers come from the predictor
        RK_NONE,    // no transfer at all
        RK_ONE,     // exactly one transfer, typed in the row, marked last
        RK_CFG      // register write: reg_sel selects, id carries the data
    } t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        logic                cmd;
        logic [PRIO_W-1:0]   prio;
        logic [ID_W-1:0]     id;
        logic [5:0]          reps;     // repeated with id counting up
        logic [OPRIO_W-1:0]  xprio;
        logic [ID_W-1:0]     xid;
        logic                xphase;
        logic [CFG_IDX_W-1:0] reg_sel;
    } t_row;

    localparam int NUM_ROWS = 36;

    // kind, command, priority, id, reps | typed priority, id, phase | register
    localparam t_row DIR_ROWS [NUM_ROWS] = '{
        // defaults: green 10, base 80, cost 10
        '{RK_NONE, CMD_TICK,   3'd0, 16'h0000, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        '{RK_NONE, CMD_ARRIVE, 3'd0, 16'h1234, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        '{RK_NONE, CMD_ARRIVE, 3'd7, 16'hFFFF, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        '{RK_NONE, CMD_ARRIVE, 3'd4, 16'h0000, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        '{RK_NONE, CMD_TICK,   3'd3, 16'h5555, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        '{RK_ITEM, CMD_ARRIVE, 3'd3, 16'hFFFF, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        '{RK_ONE,  CMD_TICK,   3'd7, 16'hFFFF, 6'd1,  2'd3, 16'hFFFF, PH_GREEN, CFG_NONE},
        '{RK_ITEM, CMD_ARRIVE, 3'd1, 16'h0000, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        '{RK_ITEM, CMD_ARRIVE, 3'd2, 16'h8001, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        '{RK_ITEM, CMD_ARRIVE, 3'd1, 16'h7FFE, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        '{RK_ITEM, CMD_TICK,   3'd0, 16'h0000, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        '{RK_ONE,  CMD_TICK,   3'd0, 16'h0000, 6'd1,  2'd2, 16'h8001, PH_GREEN, CFG_NONE},
        // one more arrival than a queue holds: the last one is dropped
        '{RK_ITEM, CMD_ARRIVE, 3'd2, 16'h0100, 6'd17, 2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        '{RK_ONE,  CMD_TICK,   3'd0, 16'h0000, 6'd1,  2'd2, 16'h0100, PH_GREEN, CFG_NONE},
        // zero cost: green drains every queue in one tick
        '{RK_CFG,  CMD_ARRIVE, 3'd0, 16'h0000, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_COST},
        '{RK_ITEM, CMD_ARRIVE, 3'd1, 16'hA000, 6'd4,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        '{RK_ITEM, CMD_ARRIVE, 3'd3, 16'h3000, 6'd2,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        '{RK_ITEM, CMD_TICK,   3'd0, 16'h0000, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        '{RK_NONE, CMD_TICK,   3'd0, 16'h0000, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        // cost above both budgets: nothing moves
        '{RK_CFG,  CMD_ARRIVE, 3'd0, 16'hFFFF, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_COST},
        '{RK_ITEM, CMD_ARRIVE, 3'd1, 16'h4242, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        '{RK_NONE, CMD_TICK,   3'd0, 16'h0000, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        // green budget exactly equal to the cost still serves one
        '{RK_CFG,  CMD_ARRIVE, 3'd0, 16'hFFFF, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_GREEN},
        '{RK_ONE,  CMD_TICK,   3'd0, 16'h0000, 6'd1,  2'd1, 16'h4242, PH_GREEN, CFG_NONE},
        '{RK_CFG,  CMD_ARRIVE, 3'd0, 16'h0000, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        // green 0, base 20, cost 10: base serves one, as it must stay above zero
        '{RK_CFG,  CMD_ARRIVE, 3'd0, 16'h0000, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_GREEN},
        '{RK_CFG,  CMD_ARRIVE, 3'd0, 16'd20,   6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_BASE},
        '{RK_CFG,  CMD_ARRIVE, 3'd0, 16'd10,   6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_COST},
        '{RK_ITEM, CMD_ARRIVE, 3'd1, 16'h0F0F, 6'd2,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        '{RK_ITEM, CMD_ARRIVE, 3'd2, 16'hF0F0, 6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        '{RK_ONE,  CMD_TICK,   3'd0, 16'h0000, 6'd1,  2'd1, 16'h0F0F, PH_BASE,  CFG_NONE},
        '{RK_ONE,  CMD_TICK,   3'd0, 16'h0000, 6'd1,  2'd1, 16'h0F10, PH_BASE,  CFG_NONE},
        // green above base: the base phase gets a negative budget
        '{RK_CFG,  CMD_ARRIVE, 3'd0, 16'd10,   6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_GREEN},
        '{RK_CFG,  CMD_ARRIVE, 3'd0, 16'd0,    6'd1,  2'd0, 16'h0000, PH_GREEN, CFG_BASE},
        '{RK_ITEM, CMD_ARRIVE, 3'd1, 16'h00FF, 6'd3,  2'd0, 16'h0000, PH_GREEN, CFG_NONE},
        '{RK_ONE,  CMD_TICK,   3'd0, 16'h0000, 6'd1,  2'd1, 16'h00FF, PH_GREEN, CFG_NONE}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    pqe_in_if  in_ch ();
    pqe_out_if out_ch ();

    priority_queue_energy_budget_drain_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state: its own copy of the queues and of the budget registers.
    logic [ID_W-1:0]  q_ids  [NUM_QUEUES][QUEUE_DEPTH];
    logic [PTR_W-1:0] q_head [NUM_QUEUES];
    logic [CNT_W-1:0] q_cnt  [NUM_QUEUES];
    logic [CFG_W-1:0] green_reg;
    logic [CFG_W-1:0] base_reg;
    logic [CFG_W-1:0] cost_reg;

    t_fwd fwd_batch [$];    // packets the last accepted item forwards, in order
    t_fwd due_fwd   [$];    // packets still owed by the block, oldest first

    int mismatches = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic pressure_on = 1'b0;
    int hold_cnt = 0;

    // Take the id at the head of queue q and advance the head.
    function automatic logic [ID_W-1:0] pop_id(input int q);
        logic [ID_W-1:0] tag;
        tag = q_ids[q][q_head[q]];
        q_head[q] = (q_head[q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : q_head[q] + 1'b1;
        q_cnt[q] = q_cnt[q] - 1'b1;
        return tag;
    endfunction

    // Apply one accepted item to the predictor and leave the packets that it
    // forwards in fwd_batch.
    function automatic void predict_forwarding(input logic cmd, input logic [PRIO_W-1:0] prio,
                                               input logic [ID_W-1:0] id);
        logic signed [BUD_W-1:0] bud;
        logic signed [BUD_W-1:0] unit;
        int q;
        int slot;
        fwd_batch.delete();
        if (cmd == CMD_ARRIVE) begin
            // queue the id unless the priority is out of range or the queue is full
            if (prio >= 1 && prio <= NUM_QUEUES) begin
                q = int'(prio) - 1;
                if (q_cnt[q] < QUEUE_DEPTH) begin
                    slot = (int'(q_head[q]) + int'(q_cnt[q])) % QUEUE_DEPTH;
                    q_ids[q][slot] = id;
                    q_cnt[q] = q_cnt[q] + 1'b1;
                end
            end
            return;
        end
        unit = $signed({2'b00, cost_reg});

        // green phase: strict priority, the budget may reach exactly zero
        bud = $signed({2'b00, green_reg});
        while (1'b1) begin
            q = NUM_QUEUES;
            for (int k = NUM_QUEUES - 1; k >= 0; k--)
                if (q_cnt[k] != 0) q = k;
            if (q == NUM_QUEUES || bud - unit < 0) break;
            bud = bud - unit;
            fwd_batch.push_back('{OPRIO_W'(q + 1), pop_id(q), PH_GREEN, 1'b0});
        end

        // base phase: priority 1 only, the budget must stay above zero
        bud = $signed({2'b00, base_reg}) - $signed({2'b00, green_reg});
        while (bud > 0 && q_cnt[0] != 0 && bud - unit > 0) begin
            bud = bud - unit;
            fwd_batch.push_back('{OPRIO_W'(1), pop_id(0), PH_BASE, 1'b0});
        end

        if (fwd_batch.size() != 0) fwd_batch[fwd_batch.size() - 1].last = 1'b1;
    endfunction

    // Offer one item, hold it until the block takes it, then record what it owes.
    task automatic offer(input logic cmd, input logic [PRIO_W-1:0] prio,
                         input logic [ID_W-1:0] id, input t_row_kind kind, input t_fwd typed);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.command      <= cmd;
        in_ch.priority_req <= prio;
        in_ch.packet_id    <= id;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        predict_forwarding(cmd, prio, id);
        case (kind)
            RK_ITEM: foreach (fwd_batch[i]) due_fwd.push_back(fwd_batch[i]);
            RK_ONE:  due_fwd.push_back(typed);
            default: ;
        endcase
    endtask

    // Drop valid, wait until every owed packet is out, then let the block settle to idle.
    task automatic settle_block();
        in_ch.valid <= 1'b0;
        while (due_fwd.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the block is idle whenever this runs.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_GREEN: green_reg = val;
            CFG_BASE:  base_reg  = val;
            CFG_COST:  cost_reg  = val;
            default:   ;
        endcase
    endtask

    // Receiver: random stalls, plus one long hold-off while the sender keeps
    // offering, so the block backs up and stalls its input.
    always @(posedge i_clk) begin
        if (pressure_on && hold_cnt < HOLD_CYCLES) begin
            out_ch.ready <= 1'b0;
            hold_cnt     <= hold_cnt + 1;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Compare every output transfer with the oldest owed packet.
    always @(posedge i_clk) begin
        t_fwd want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (due_fwd.size() == 0) begin
                $error("transfer with nothing owed: out_packet_id %0h", out_ch.out_packet_id);
                mismatches++;
            end else begin
                want = due_fwd.pop_front();
                if (out_ch.out_priority !== want.prio) begin
                    $error("out_priority: expected %0d, got %0d", want.prio, out_ch.out_priority);
                    mismatches++;
                end
                if (out_ch.out_packet_id !== want.id) begin
                    $error("out_packet_id: expected %0h, got %0h", want.id, out_ch.out_packet_id);
                    mismatches++;
                end
                if (out_ch.budget_phase !== want.phase) begin
                    $error("budget_phase: expected %0d, got %0d", want.phase, out_ch.budget_phase);
                    mismatches++;
                end
                if (out_ch.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, out_ch.last);
                    mismatches++;
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(2 * LIMIT_CYCLES);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_row             row;
        t_fwd             typed;
        int               phase;
        int               sent;
        int               tick_odds;
        logic             cmd;
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]  id;
        logic [CFG_W-1:0] g_val;
        logic [CFG_W-1:0] b_val;
        logic [CFG_W-1:0] c_val;

        // Hold every input at a known value through reset.
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_GREEN;
        i_cfg_data         = '0;
        in_ch.valid        = 1'b0;
        in_ch.command      = CMD_ARRIVE;
        in_ch.priority_req = '0;
        in_ch.packet_id    = '0;

        for (int q = 0; q < NUM_QUEUES; q++) begin
            q_head[q] = '0;
            q_cnt[q]  = '0;
            for (int s = 0; s < QUEUE_DEPTH; s++) q_ids[q][s] = '0;
        end
        green_reg = GREEN_RST;
        base_reg  = BASE_RST;
        cost_reg  = COST_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: sender idles lightly, receiver heavily.
        tx_idle_pct = 15;
        rx_idle_pct <= 49;
        foreach (DIR_ROWS[r]) begin
            row = DIR_ROWS[r];
            if (row.kind == RK_CFG) begin
                settle_block();
                write_reg(row.reg_sel, row.id);
            end else begin
                typed = '{row.xprio, row.xid, row.xphase, 1'b1};
                for (int k = 0; k < row.reps; k++)
                    offer(row.cmd, row.prio, row.id + ID_W'(k), row.kind, typed);
            end
        end

        // Random phases, each under its own budget setting.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            settle_block();
            case (phase)
                0: begin   // small budgets, a few packets per tick
                    g_val = CFG_W'($urandom_range(0, 40));
                    b_val = CFG_W'($urandom_range(0, 120));
                    c_val = CFG_W'($urandom_range(1, 15));
                end
                1: begin   // zero cost, rare ticks: full queues drain at once
                    g_val = CFG_W'($urandom_range(0, 200));
                    b_val = CFG_W'($urandom_range(0, 200));
                    c_val = '0;
                end
                2: begin   // budgets at the top of their range
                    g_val = '1;
                    b_val = '1;
                    c_val = CFG_W'($urandom_range(1, 4000));
                end
                3: begin   // any register value at all
                    g_val = CFG_W'($urandom);
                    b_val = CFG_W'($urandom);
                    c_val = CFG_W'($urandom);
                end
                4: begin   // green above base
                    g_val = CFG_W'($urandom_range(20, 60));
                    b_val = CFG_W'($urandom_range(0, 19));
                    c_val = CFG_W'($urandom_range(1, 10));
                end
                default: begin
                    g_val = CFG_W'($urandom_range(0, 30));
                    b_val = CFG_W'($urandom_range(30, 300));
                    c_val = CFG_W'($urandom_range(5, 30));
                end
            endcase
            write_reg(CFG_GREEN, g_val);
            write_reg(CFG_BASE, b_val);
            write_reg(CFG_COST, c_val);

            // swap the idle pattern after two phases, then stop idling
            if (phase < 2) begin
                tx_idle_pct = 15;
                rx_idle_pct <= 49;
            end else if (phase < 4) begin
                tx_idle_pct = 49;
                rx_idle_pct <= 15;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            if (phase == PRESSURE_PHASE) pressure_on <= 1'b1;
            tick_odds = (phase == 1) ? 16 : 4;

            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                cmd = ($urandom_range(0, tick_odds - 1) == 0) ? CMD_TICK : CMD_ARRIVE;
                if (cmd == CMD_TICK)
                    prio = PRIO_W'($urandom_range(0, 7));
                else if ($urandom_range(0, 99) < 8)
                    prio = ($urandom_range(0, 1) == 0) ? PRIO_W'(0) : PRIO_W'($urandom_range(4, 7));
                else
                    prio = PRIO_W'($urandom_range(1, 3));
                id = ID_W'($urandom);
                offer(cmd, prio, id, RK_ITEM, '0);
                // ignored arrivals do not count toward the phase
                if (cmd == CMD_TICK || (prio >= 1 && prio <= NUM_QUEUES)) sent++;
            end
        end

        settle_block();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* priority_queue_energy_budget_drain_core.f */
rtl/core/pqe_pkg.sv
rtl/core/pqe_if.sv
rtl/core/pqe_alu.sv
rtl/core/pqe_store.sv
rtl/core/pqe_qctl.sv
rtl/core/priority_queue_energy_budget_drain_core.sv
rtl/core/pqe_checker.sv
test/tb_priority_queue_energy_budget_drain_core.sv
